// ----- rtl/core/cia_pkg.sv -----
package cia_pkg;

  localparam int OUT_W = 40;

  typedef enum logic [2:0] {
    OP_EQ  = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4
  } cia_op_t;

  // Sideband that rides along the divider pipeline.
  typedef struct packed {
    logic                    is_div;
    logic                    dz;
    logic                    eq;
    logic                    neg_re;
    logic                    neg_im;
    logic signed [OUT_W-1:0] gen_re;
    logic signed [OUT_W-1:0] gen_im;
  } cia_side_t;

endpackage

// ----- rtl/core/cia_div.sv -----
module cia_div #(
  parameter int DW = 32,
  parameter int QW = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DW-1:0]       in_d,
  input  logic [QW-1:0]       in_n_re,
  input  logic [QW-1:0]       in_n_im,
  input  cia_pkg::cia_side_t  in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [QW-1:0]       out_q_re,
  output logic [QW-1:0]       out_q_im,
  output cia_pkg::cia_side_t  out_side
);
  import cia_pkg::*;

  // One restoring step: the dividend shifts out at the top of nq while
  // quotient bits shift in at the bottom.
  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QW-1:0] nq,
                                                input logic [DW-1:0] d);
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    trial = {rem, nq[QW-1]};
    ge    = (trial >= {1'b0, d});
    diff  = trial - {1'b0, d};
    return {(ge ? diff[DW-1:0] : trial[DW-1:0]), nq[QW-2:0], ge};
  endfunction

  logic            v_r        [QW];
  logic [QW-1:0]   nq_re_r    [QW];
  logic [QW-1:0]   nq_im_r    [QW];
  cia_side_t       side_r     [QW];
  logic [DW-1:0]   rem_re_r   [QW-1];
  logic [DW-1:0]   rem_im_r   [QW-1];
  logic [DW-1:0]   d_r        [QW-1];

  logic            en         [QW];
  logic            src_v      [QW];
  logic [DW-1:0]   src_rem_re [QW];
  logic [DW-1:0]   src_rem_im [QW];
  logic [DW-1:0]   src_d      [QW];
  logic [QW-1:0]   src_nq_re  [QW];
  logic [QW-1:0]   src_nq_im  [QW];
  cia_side_t       src_side   [QW];
  logic [DW-1:0]   rem_re_nxt [QW];
  logic [DW-1:0]   rem_im_nxt [QW];
  logic [QW-1:0]   nq_re_nxt  [QW];
  logic [QW-1:0]   nq_im_nxt  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign src_v[i]      = in_valid;
      assign src_rem_re[i] = '0;
      assign src_rem_im[i] = '0;
      assign src_d[i]      = in_d;
      assign src_nq_re[i]  = in_n_re;
      assign src_nq_im[i]  = in_n_im;
      assign src_side[i]   = in_side;
    end else begin : g_rest
      assign src_v[i]      = v_r[i-1];
      assign src_rem_re[i] = rem_re_r[i-1];
      assign src_rem_im[i] = rem_im_r[i-1];
      assign src_d[i]      = d_r[i-1];
      assign src_nq_re[i]  = nq_re_r[i-1];
      assign src_nq_im[i]  = nq_im_r[i-1];
      assign src_side[i]   = side_r[i-1];
    end

    if (i == QW - 1) begin : g_en_last
      assign en[i] = !v_r[i] || out_ready;
    end else begin : g_en_mid
      assign en[i] = !v_r[i] || en[i+1];
    end

    assign {rem_re_nxt[i], nq_re_nxt[i]} = div_step(src_rem_re[i], src_nq_re[i], src_d[i]);
    assign {rem_im_nxt[i], nq_im_nxt[i]} = div_step(src_rem_im[i], src_nq_im[i], src_d[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en[i]) begin
        v_r[i] <= src_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        nq_re_r[i] <= nq_re_nxt[i];
        nq_im_r[i] <= nq_im_nxt[i];
        side_r[i]  <= src_side[i];
      end
    end

    // The last step leaves only the quotient; its remainder is not kept.
    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[i]) begin
          rem_re_r[i] <= rem_re_nxt[i];
          rem_im_r[i] <= rem_im_nxt[i];
          d_r[i]      <= src_d[i];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[QW-1];
  assign out_q_re  = nq_re_r[QW-1];
  assign out_q_im  = nq_im_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ----- rtl/core/complex_integer_alu.sv -----
// Complex integer ALU: equality, add, subtract, multiply and fixed-point divide.
// Every op goes through the same pipeline: three operand stages, one restoring divider
// step per quotient bit, two result stages.
// Throughput is one transfer per cycle when out_ready does not stall the output.
// Reset (rst_n, synchronous, active low) clears only the stage valid bits.
module complex_integer_alu #(
  parameter int OPERAND_WIDTH = 16,
  parameter int FRAC_BITS     = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_op,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_real,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_imag,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_real,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_imag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [39:0]              out_res_real,
  output logic signed [39:0]              out_res_imag,
  output logic                            out_is_equal,
  output logic                            out_div_by_zero,
  output logic                            out_saturated
);
  import cia_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int QW = PW + FRAC_BITS;
  localparam int EW = (PW + 1 > OUT_W) ? PW + 1 : OUT_W;
  localparam int CW = (QW > OUT_W) ? QW : OUT_W;

  // Stage 1: products, add/subtract and equality straight from the operands.
  logic                    s1_v_r;
  cia_op_t                 s1_op_r;
  logic                    s1_eq_r;
  logic signed [OUT_W-1:0] s1_gen_re_r, s1_gen_im_r;
  logic signed [PW-1:0]    s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r;
  logic signed [PW-1:0]    s1_p_bbr_r, s1_p_bbi_r;
  cia_op_t                 s1_op_nxt;
  logic                    s1_eq_nxt;
  logic signed [OUT_W-1:0] s1_gen_re_nxt, s1_gen_im_nxt;
  logic signed [W:0]       add_re, add_im, sub_re, sub_im;
  logic                    en1;

  // Stage 2: sums of products and the squared divisor magnitude.
  logic                    s2_v_r;
  cia_op_t                 s2_op_r;
  logic                    s2_eq_r;
  logic signed [OUT_W-1:0] s2_gen_re_r, s2_gen_im_r;
  logic signed [PW:0]      s2_num_re_r, s2_num_im_r;
  logic [PW-1:0]           s2_d_r;
  logic signed [PW:0]      mul_re, mul_im, num_re, num_im;
  logic signed [EW-1:0]    mul_re_ext, mul_im_ext;
  logic signed [OUT_W-1:0] s2_gen_re_nxt, s2_gen_im_nxt;
  logic [PW-1:0]           s2_d_nxt;
  logic                    en2;

  // Stage 3: sign and magnitude of the divide numerators.
  logic                    s3_v_r;
  cia_side_t               s3_side_r;
  logic [PW-1:0]           s3_d_r, s3_mag_re_r, s3_mag_im_r;
  cia_side_t               s3_side_nxt;
  logic signed [PW:0]      neg_num_re, neg_num_im;
  logic [PW-1:0]           s3_mag_re_nxt, s3_mag_im_nxt;
  logic                    en3;

  // Divider.
  logic                    div_in_ready;
  logic                    div_out_valid;
  logic [QW-1:0]           div_q_re, div_q_im;
  cia_side_t               div_side;
  logic [QW-1:0]           div_n_re, div_n_im;

  // Stage 4: clamp the quotient magnitudes.
  logic                    s4_v_r;
  cia_side_t               s4_side_r;
  logic [OUT_W-1:0]        s4_mag_re_r, s4_mag_im_r;
  logic                    s4_sat_r;
  logic [CW-1:0]           q_re_x, q_im_x, lim_re, lim_im, lim_pos, lim_neg;
  logic                    sat_re, sat_im;
  logic [CW-1:0]           clip_re, clip_im;
  logic                    en4;

  // Output register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_re_r, out_im_r;
  logic                    out_eq_r, out_dz_r, out_sat_r;
  logic signed [OUT_W-1:0] out_re_nxt, out_im_nxt;
  logic                    out_eq_nxt, out_dz_nxt, out_sat_nxt;
  logic                    en_out;

  // Each stage takes a new transfer when it is empty or its contents move on.
  assign en_out   = !out_valid_r || out_ready;
  assign en4      = !s4_v_r || en_out;
  assign en3      = !s3_v_r || div_in_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  // ---------------- Stage 1 ----------------
  always_comb begin
    s1_op_nxt     = cia_op_t'(in_op);
    add_re        = (W+1)'(in_a_real) + (W+1)'(in_b_real);
    add_im        = (W+1)'(in_a_imag) + (W+1)'(in_b_imag);
    sub_re        = (W+1)'(in_a_real) - (W+1)'(in_b_real);
    sub_im        = (W+1)'(in_a_imag) - (W+1)'(in_b_imag);
    s1_eq_nxt     = 1'b0;
    s1_gen_re_nxt = '0;
    s1_gen_im_nxt = '0;
    case (s1_op_nxt)
      OP_EQ: begin
        s1_eq_nxt = (in_a_real == in_b_real) && (in_a_imag == in_b_imag);
      end
      OP_ADD: begin
        s1_gen_re_nxt = OUT_W'(add_re);
        s1_gen_im_nxt = OUT_W'(add_im);
      end
      OP_SUB: begin
        s1_gen_re_nxt = OUT_W'(sub_re);
        s1_gen_im_nxt = OUT_W'(sub_im);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r     <= s1_op_nxt;
      s1_eq_r     <= s1_eq_nxt;
      s1_gen_re_r <= s1_gen_re_nxt;
      s1_gen_im_r <= s1_gen_im_nxt;
      s1_p_rr_r   <= PW'(in_a_real) * PW'(in_b_real);
      s1_p_ii_r   <= PW'(in_a_imag) * PW'(in_b_imag);
      s1_p_ri_r   <= PW'(in_a_real) * PW'(in_b_imag);
      s1_p_ir_r   <= PW'(in_a_imag) * PW'(in_b_real);
      s1_p_bbr_r  <= PW'(in_b_real) * PW'(in_b_real);
      s1_p_bbi_r  <= PW'(in_b_imag) * PW'(in_b_imag);
    end
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    mul_re     = (PW+1)'(s1_p_rr_r) - (PW+1)'(s1_p_ii_r);
    mul_im     = (PW+1)'(s1_p_ri_r) + (PW+1)'(s1_p_ir_r);
    num_re     = (PW+1)'(s1_p_rr_r) + (PW+1)'(s1_p_ii_r);
    num_im     = (PW+1)'(s1_p_ir_r) - (PW+1)'(s1_p_ri_r);
    mul_re_ext = EW'(mul_re);
    mul_im_ext = EW'(mul_im);
    s2_d_nxt   = $unsigned(s1_p_bbr_r) + $unsigned(s1_p_bbi_r);
    if (s1_op_r == OP_MUL) begin
      s2_gen_re_nxt = mul_re_ext[OUT_W-1:0];
      s2_gen_im_nxt = mul_im_ext[OUT_W-1:0];
    end else begin
      s2_gen_re_nxt = s1_gen_re_r;
      s2_gen_im_nxt = s1_gen_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r     <= s1_op_r;
      s2_eq_r     <= s1_eq_r;
      s2_gen_re_r <= s2_gen_re_nxt;
      s2_gen_im_r <= s2_gen_im_nxt;
      s2_num_re_r <= num_re;
      s2_num_im_r <= num_im;
      s2_d_r      <= s2_d_nxt;
    end
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    neg_num_re         = -s2_num_re_r;
    neg_num_im         = -s2_num_im_r;
    s3_mag_re_nxt      = s2_num_re_r[PW] ? neg_num_re[PW-1:0] : s2_num_re_r[PW-1:0];
    s3_mag_im_nxt      = s2_num_im_r[PW] ? neg_num_im[PW-1:0] : s2_num_im_r[PW-1:0];
    s3_side_nxt.is_div = (s2_op_r == OP_DIV) && (s2_d_r != '0);
    s3_side_nxt.dz     = (s2_op_r == OP_DIV) && (s2_d_r == '0);
    s3_side_nxt.eq     = s2_eq_r;
    s3_side_nxt.neg_re = s2_num_re_r[PW];
    s3_side_nxt.neg_im = s2_num_im_r[PW];
    s3_side_nxt.gen_re = s2_gen_re_r;
    s3_side_nxt.gen_im = s2_gen_im_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_side_r   <= s3_side_nxt;
      s3_d_r      <= s2_d_r;
      s3_mag_re_r <= s3_mag_re_nxt;
      s3_mag_im_r <= s3_mag_im_nxt;
    end
  end

  // ---------------- Divider ----------------
  assign div_n_re = QW'(s3_mag_re_r) << FRAC_BITS;
  assign div_n_im = QW'(s3_mag_im_r) << FRAC_BITS;

  cia_div #(
    .DW (PW),
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_ready  (div_in_ready),
    .in_d      (s3_d_r),
    .in_n_re   (div_n_re),
    .in_n_im   (div_n_im),
    .in_side   (s3_side_r),
    .out_valid (div_out_valid),
    .out_ready (en4),
    .out_q_re  (div_q_re),
    .out_q_im  (div_q_im),
    .out_side  (div_side)
  );

  // ---------------- Stage 4 ----------------
  // A negative quotient may reach one more than a positive one.
  always_comb begin
    lim_pos = CW'({1'b0, {(OUT_W-1){1'b1}}});
    lim_neg = CW'({1'b1, {(OUT_W-1){1'b0}}});
    q_re_x  = CW'(div_q_re);
    q_im_x  = CW'(div_q_im);
    lim_re  = div_side.neg_re ? lim_neg : lim_pos;
    lim_im  = div_side.neg_im ? lim_neg : lim_pos;
    sat_re  = q_re_x > lim_re;
    sat_im  = q_im_x > lim_im;
    clip_re = sat_re ? lim_re : q_re_x;
    clip_im = sat_im ? lim_im : q_im_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_side_r   <= div_side;
      s4_mag_re_r <= clip_re[OUT_W-1:0];
      s4_mag_im_r <= clip_im[OUT_W-1:0];
      s4_sat_r    <= sat_re || sat_im;
    end
  end

  // ---------------- Output register ----------------
  always_comb begin
    out_re_nxt  = s4_side_r.gen_re;
    out_im_nxt  = s4_side_r.gen_im;
    out_eq_nxt  = s4_side_r.eq;
    out_dz_nxt  = s4_side_r.dz;
    out_sat_nxt = 1'b0;
    if (s4_side_r.dz) begin
      out_re_nxt = '0;
      out_im_nxt = '0;
    end else if (s4_side_r.is_div) begin
      out_re_nxt  = s4_side_r.neg_re ? -$signed(s4_mag_re_r) : $signed(s4_mag_re_r);
      out_im_nxt  = s4_side_r.neg_im ? -$signed(s4_mag_im_r) : $signed(s4_mag_im_r);
      out_sat_nxt = s4_sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_re_r  <= out_re_nxt;
      out_im_r  <= out_im_nxt;
      out_eq_r  <= out_eq_nxt;
      out_dz_r  <= out_dz_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_real    = out_re_r;
  assign out_res_imag    = out_im_r;
  assign out_is_equal    = out_eq_r;
  assign out_div_by_zero = out_dz_r;
  assign out_saturated   = out_sat_r;

endmodule
